FILE: rtl/kwm_pkg.sv
package kwm_pkg;

  localparam int LISTS       = 8;
  localparam int QUEUE_DEPTH = 64;

  localparam int LI_W   = $clog2(LISTS);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(LISTS * QUEUE_DEPTH);

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_TAKE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ORDER = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_LOAD_BAD,
    OP_TAKE,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0]         list_index;
    logic signed [15:0] value;
  } in_t;

  typedef struct packed {
    logic signed [15:0] result_value;
    logic [1:0]         status;
    logic               drained;
  } out_t;

  typedef struct packed {
    op_e                op;
    logic [LI_W-1:0]    list;
    logic signed [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

endpackage

FILE: rtl/k_way_sorted_merge.sv
// channel   ports                         word      handshake
// command   start, busy, in_i             in_t      taken when start && !busy
// result    out_valid_o, out_o            out_t     one-cycle strobe, no stall
//
// Load, clear and unused codes execute without a refill step; a take that leaves its list
// non-empty is followed by a refill state that loads that list's head register from
// the queue memory read port. Results appear the cycle after execution.
// A 2-word command queue lets commands arrive while the executor works.
// Reset (rst_ni low, async) empties every list; queue memory is not cleared.
module k_way_sorted_merge (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  kwm_pkg::in_t  in_i,
  output logic          out_valid_o,
  output kwm_pkg::out_t out_o
);
  import kwm_pkg::*;

  cmd_req_t req;
  logic     ready;

  kwm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .in_i    (in_i),
    .req_o   (req),
    .ready_i (ready)
  );

  kwm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

FILE: rtl/kwm_front.sv
module kwm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  kwm_pkg::in_t    in_i,
  output kwm_pkg::cmd_req_t req_o,
  input  logic            ready_i
);
  import kwm_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.list  = LI_W'(in_i.list_index);
    cmd_in.value = in_i.value;
    case (in_i.mode)
      MODE_LOAD: begin
        if (int'(in_i.list_index) < LISTS) begin
          cmd_in.op = OP_LOAD;
        end else begin
          cmd_in.op = OP_LOAD_BAD;
        end
      end
      MODE_TAKE:  cmd_in.op = OP_TAKE;
      MODE_CLEAR: cmd_in.op = OP_CLEAR;
      default:    cmd_in.op = OP_NOP;
    endcase
  end

  assign busy  = (cnt_q == 2'd2);
  assign push  = start && !busy;
  assign pop   = ready_i && (cnt_q != 2'd0);
  assign wr_d  = push ? ~wr_q : wr_q;
  assign rd_d  = pop ? ~rd_q : rd_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  assign req_o.valid = (cnt_q != 2'd0);
  assign req_o.cmd   = fifo_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= cmd_in;
    end
  end

endmodule

FILE: rtl/kwm_back.sv
module kwm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kwm_pkg::cmd_req_t req_i,
  output logic              ready_o,
  output logic              out_valid_o,
  output kwm_pkg::out_t     out_o
);
  import kwm_pkg::*;

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_REFILL = 1'b1;

  localparam logic [PTR_W:0]    DEPTH_S = (PTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0]  PTR_MAX = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

  logic                  state_q, state_d;
  logic [PTR_W-1:0]      rp_q   [LISTS];
  logic [PTR_W-1:0]      rp_d   [LISTS];
  logic [FILL_W-1:0]     fill_q [LISTS];
  logic [FILL_W-1:0]     fill_d [LISTS];
  logic signed [15:0]    last_q [LISTS];
  logic signed [15:0]    last_d [LISTS];
  logic                  has_q  [LISTS];
  logic                  has_d  [LISTS];
  logic signed [15:0]    head_q [LISTS];
  logic [LI_W-1:0]       refill_q, refill_d;

  logic signed [15:0]    mem [LISTS * QUEUE_DEPTH];
  logic signed [15:0]    rdata_q;
  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     waddr, raddr;

  logic                  head_we;
  logic [LI_W-1:0]       head_idx;
  logic signed [15:0]    head_wdata;

  logic                  out_valid_d;
  out_t                  out_d;
  logic                  pop;

  logic                  found;
  logic [LI_W-1:0]       best;
  logic signed [15:0]    best_val;
  logic [PTR_W:0]        slot;
  logic [PTR_W-1:0]      rp_nx;
  logic                  any_left;

  assign ready_o = (state_q == S_IDLE);
  assign pop     = ready_o && req_i.valid;

  always_comb begin
    found    = 1'b0;
    best     = '0;
    best_val = '0;
    for (int i = 0; i < LISTS; i++) begin
      if (fill_q[i] != '0 && (!found || head_q[i] < best_val)) begin
        found    = 1'b1;
        best     = LI_W'(i);
        best_val = head_q[i];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    refill_d    = refill_q;
    rp_d        = rp_q;
    fill_d      = fill_q;
    last_d      = last_q;
    has_d       = has_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    waddr       = '0;
    raddr       = '0;
    head_we     = 1'b0;
    head_idx    = refill_q;
    head_wdata  = rdata_q;
    out_valid_d = 1'b0;
    out_d       = '0;
    slot        = '0;
    rp_nx       = '0;
    any_left    = 1'b0;

    if (state_q == S_REFILL) begin
      head_we = 1'b1;
      state_d = S_IDLE;
    end else if (pop) begin
      out_valid_d = 1'b1;
      out_d.status = ST_OK;
      case (req_i.cmd.op)
        OP_LOAD: begin
          for (int i = 0; i < LISTS; i++) begin
            if (req_i.cmd.list == LI_W'(i)) begin
              if (fill_q[i] == FILL_MAX) begin
                out_d.status = ST_FULL;
              end else if (has_q[i] && req_i.cmd.value < last_q[i]) begin
                out_d.status = ST_ORDER;
              end else begin
                slot = (PTR_W + 1)'(rp_q[i]) + (PTR_W + 1)'(fill_q[i]);
                if (slot >= DEPTH_S) begin
                  slot = slot - DEPTH_S;
                end
                mem_we    = 1'b1;
                waddr     = ADDR_W'(ADDR_W'(i) * ADDR_W'(QUEUE_DEPTH))
                            + ADDR_W'(slot);
                fill_d[i] = fill_q[i] + FILL_W'(1);
                last_d[i] = req_i.cmd.value;
                has_d[i]  = 1'b1;
                if (fill_q[i] == '0) begin
                  head_we    = 1'b1;
                  head_idx   = LI_W'(i);
                  head_wdata = req_i.cmd.value;
                end
              end
            end
          end
        end
        OP_LOAD_BAD: out_d.status = ST_FULL;
        OP_TAKE: begin
          if (!found) begin
            out_d.status = ST_EMPTY;
          end else begin
            out_d.result_value = best_val;
            for (int i = 0; i < LISTS; i++) begin
              if (best == LI_W'(i)) begin
                rp_nx     = (rp_q[i] == PTR_MAX) ? '0 : rp_q[i] + PTR_W'(1);
                rp_d[i]   = rp_nx;
                fill_d[i] = fill_q[i] - FILL_W'(1);
                if (fill_q[i] > FILL_W'(1)) begin
                  mem_re   = 1'b1;
                  raddr    = ADDR_W'(ADDR_W'(i) * ADDR_W'(QUEUE_DEPTH))
                             + ADDR_W'(rp_nx);
                  refill_d = LI_W'(i);
                  state_d  = S_REFILL;
                end
              end
            end
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < LISTS; i++) begin
            rp_d[i]   = '0;
            fill_d[i] = '0;
            last_d[i] = '0;
            has_d[i]  = 1'b0;
          end
        end
        default: ;
      endcase
      for (int i = 0; i < LISTS; i++) begin
        any_left = any_left | (fill_d[i] != '0);
      end
      out_d.drained = !any_left;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      refill_q    <= '0;
      out_valid_o <= 1'b0;
      for (int i = 0; i < LISTS; i++) begin
        rp_q[i]   <= '0;
        fill_q[i] <= '0;
        last_q[i] <= '0;
        has_q[i]  <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      refill_q    <= refill_d;
      out_valid_o <= out_valid_d;
      rp_q        <= rp_d;
      fill_q      <= fill_d;
      last_q      <= last_d;
      has_q       <= has_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_o <= out_d;
    for (int i = 0; i < LISTS; i++) begin
      if (head_we && head_idx == LI_W'(i)) begin
        head_q[i] <= head_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= req_i.cmd.value;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  refill_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_REFILL |=> state_q == S_IDLE)
    else $error("head refill took more than one cycle");

  strobe_follows_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_d |-> pop)
    else $error("result word without a command");

  refill_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_REFILL |-> fill_q[refill_q] != '0)
    else $error("refill of an empty queue");

endmodule
